[design/clle_pkg.sv]
`timescale 1ns / 1ps
package clle_pkg;

  // Operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_AMEND  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOTFND = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Fixed entries: free chain head and list sentinel
  localparam int FREE_HEAD = 0;
  localparam int LIST_HEAD = 1;

  // Link read address select
  localparam logic [1:0] LRA_FREE  = 2'd0;
  localparam logic [1:0] LRA_HEAD  = 2'd1;
  localparam logic [1:0] LRA_LDATA = 2'd2;
  localparam logic [1:0] LRA_FRESH = 2'd3;

  // Link write address select
  localparam logic [2:0] LWA_FREE  = 3'd0;
  localparam logic [2:0] LWA_FRESH = 3'd1;
  localparam logic [2:0] LWA_PRED  = 3'd2;
  localparam logic [2:0] LWA_CUR   = 3'd3;
  localparam logic [2:0] LWA_CLR   = 3'd4;

  // Link write data select
  localparam logic [1:0] LWD_LDATA = 2'd0;
  localparam logic [1:0] LWD_FRESH = 2'd1;
  localparam logic [1:0] LWD_CUR   = 2'd2;
  localparam logic [1:0] LWD_CLR   = 2'd3;

  // Result index source
  localparam logic [1:0] RES_NONE  = 2'd0;
  localparam logic [1:0] RES_FRESH = 2'd1;
  localparam logic [1:0] RES_CUR   = 2'd2;

  typedef struct packed {
    logic       cap;
    logic [1:0] lra;
    logic       lwe;
    logic [2:0] lwa;
    logic [1:0] lwd;
    logic       vwe;
    logic       vw_amend;
    logic       fresh_ld;
    logic       p_head;
    logic       ins_adv;
    logic       c_ld;
    logic       find_adv;
    logic       clr_adv;
    logic       res_ld;
    logic [1:0] res_status;
    logic [1:0] res_src;
    logic       out_ld;
  } clle_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       link_zero;
    logic       val_match;
    logic       more;
    logic       clr_last;
    logic       out_free;
  } clle_stat_t;

endpackage

[design/clle_ram.sv]
`timescale 1ns / 1ps
module clle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/clle_dpath.sv]
`timescale 1ns / 1ps
module clle_dpath import clle_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  clle_cmd_t    cmd,
  output clle_stat_t   stat,
  input  logic [1:0]   operation,
  input  logic [31:0]  value,
  input  logic [31:0]  new_value,
  input  logic [15:0]  position,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [1:0]   status,
  output logic [5:0]   entry_index
);

  localparam int AW = $clog2(DEPTH);

  logic [1:0]    op_r;
  logic [31:0]   v_r;
  logic [31:0]   nv_r;
  logic [15:0]   pos_r;
  logic [AW-1:0] fresh;
  logic [AW-1:0] p;
  logic [AW-1:0] c;
  logic [15:0]   cnt;
  logic [AW-1:0] clr;
  logic [1:0]    res_status;
  logic [AW-1:0] res_idx;

  logic [AW-1:0] lraddr, lwaddr, lwdata, ldata, clr_data;
  logic [AW-1:0] vwaddr;
  logic [31:0]   vwdata, vdata;
  logic [31:0]   res_wide;

  // Link memory addressing
  always_comb begin
    case (cmd.lra)
      LRA_FREE:  lraddr = AW'(FREE_HEAD);
      LRA_HEAD:  lraddr = AW'(LIST_HEAD);
      LRA_LDATA: lraddr = ldata;
      LRA_FRESH: lraddr = fresh;
      default:   lraddr = AW'(FREE_HEAD);
    endcase
    case (cmd.lwa)
      LWA_FREE:  lwaddr = AW'(FREE_HEAD);
      LWA_FRESH: lwaddr = fresh;
      LWA_PRED:  lwaddr = p;
      LWA_CUR:   lwaddr = c;
      LWA_CLR:   lwaddr = clr;
      default:   lwaddr = AW'(FREE_HEAD);
    endcase
    case (cmd.lwd)
      LWD_LDATA: lwdata = ldata;
      LWD_FRESH: lwdata = fresh;
      LWD_CUR:   lwdata = c;
      LWD_CLR:   lwdata = clr_data;
      default:   lwdata = ldata;
    endcase
  end

  // Initial chain: free head points at entry 2, sentinel and last entry end chains
  always_comb begin
    if (clr == AW'(FREE_HEAD)) begin
      clr_data = AW'(2);
    end else if (clr == AW'(LIST_HEAD) || clr == AW'(DEPTH - 1)) begin
      clr_data = '0;
    end else begin
      clr_data = clr + AW'(1);
    end
  end

  assign vwaddr = cmd.vw_amend ? c : fresh;
  assign vwdata = cmd.vw_amend ? nv_r : v_r;

  clle_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_link (
    .clk   (clk),
    .we    (cmd.lwe),
    .waddr (lwaddr),
    .wdata (lwdata),
    .raddr (lraddr),
    .rdata (ldata)
  );

  clle_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_value (
    .clk   (clk),
    .we    (cmd.vwe),
    .waddr (vwaddr),
    .wdata (vwdata),
    .raddr (ldata),
    .rdata (vdata)
  );

  // Hold request fields and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= operation;
      v_r   <= value;
      nv_r  <= new_value;
      pos_r <= position;
    end
    if (cmd.fresh_ld) begin
      fresh <= ldata;
    end
    if (cmd.p_head) begin
      p   <= AW'(LIST_HEAD);
      cnt <= 16'd1;
    end else if (cmd.ins_adv) begin
      p   <= ldata;
      cnt <= cnt + 16'd1;
    end else if (cmd.find_adv) begin
      p <= c;
    end
    if (cmd.c_ld || cmd.find_adv) begin
      c <= ldata;
    end
    if (cmd.res_ld) begin
      res_status <= cmd.res_status;
      case (cmd.res_src)
        RES_FRESH: res_idx <= fresh;
        RES_CUR:   res_idx <= c;
        default:   res_idx <= '0;
      endcase
    end
    if (cmd.out_ld) begin
      status      <= res_status;
      entry_index <= res_wide[5:0];
    end
  end

  assign res_wide = 32'(res_idx);

  // Advance clearing pass and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_adv) begin
        clr <= clr + AW'(1);
      end
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.op        = op_r;
  assign stat.link_zero = (ldata == '0);
  assign stat.val_match = (vdata == v_r);
  assign stat.more      = (cnt < pos_r);
  assign stat.clr_last  = (clr == AW'(DEPTH - 1));
  assign stat.out_free  = !out_valid || out_ready;

  a_no_self_link: assert property (@(posedge clk) disable iff (rst)
    cmd.lwe && lwaddr != AW'(FREE_HEAD) |-> lwaddr != lwdata)
    else $error("link write creates a self loop");

  a_value_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.vwe |-> vwaddr != AW'(FREE_HEAD) && vwaddr != AW'(LIST_HEAD))
    else $error("value written to a reserved entry");

  a_ok_index: assert property (@(posedge clk) disable iff (rst)
    cmd.res_ld && cmd.res_status == ST_OK |-> cmd.res_src != RES_NONE)
    else $error("success reported without an entry");

  a_fresh_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.res_ld && cmd.res_src == RES_FRESH
      |-> fresh != AW'(FREE_HEAD) && fresh != AW'(LIST_HEAD))
    else $error("insert used a reserved entry");

endmodule

[design/clle_ctrl.sv]
`timescale 1ns / 1ps
module clle_ctrl import clle_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  clle_stat_t stat,
  output clle_cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_I1    = 4'd3;
  localparam logic [3:0] S_I2    = 4'd4;
  localparam logic [3:0] S_IWALK = 4'd5;
  localparam logic [3:0] S_I4    = 4'd6;
  localparam logic [3:0] S_F1    = 4'd7;
  localparam logic [3:0] S_FWALK = 4'd8;
  localparam logic [3:0] S_D1    = 4'd9;
  localparam logic [3:0] S_D2    = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Sequence each operation over the link and value memories
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.lwe     = 1'b1;
        cmd.lwa     = LWA_CLR;
        cmd.lwd     = LWD_CLR;
        cmd.clr_adv = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.op == OP_INSERT) begin
          cmd.lra    = LRA_FREE;
          state_next = S_I1;
        end else begin
          cmd.lra    = LRA_HEAD;
          cmd.p_head = 1'b1;
          state_next = S_F1;
        end
      end
      S_I1: begin
        // fresh entry is on the read port now; fetch its link
        cmd.fresh_ld = 1'b1;
        if (stat.link_zero) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_FULL;
          cmd.res_src    = RES_NONE;
          state_next     = S_FIN;
        end else begin
          cmd.lra    = LRA_LDATA;
          state_next = S_I2;
        end
      end
      S_I2: begin
        // pop fresh entry off the free chain
        cmd.lwe    = 1'b1;
        cmd.lwa    = LWA_FREE;
        cmd.lwd    = LWD_LDATA;
        cmd.p_head = 1'b1;
        cmd.lra    = LRA_HEAD;
        state_next = S_IWALK;
      end
      S_IWALK: begin
        if (stat.more && !stat.link_zero) begin
          cmd.ins_adv = 1'b1;
          cmd.lra     = LRA_LDATA;
        end else begin
          cmd.lwe    = 1'b1;
          cmd.lwa    = LWA_FRESH;
          cmd.lwd    = LWD_LDATA;
          cmd.vwe    = 1'b1;
          state_next = S_I4;
        end
      end
      S_I4: begin
        cmd.lwe        = 1'b1;
        cmd.lwa        = LWA_PRED;
        cmd.lwd        = LWD_FRESH;
        cmd.res_ld     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_src    = RES_FRESH;
        state_next     = S_FIN;
      end
      S_F1: begin
        if (stat.link_zero) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_NOTFND;
          cmd.res_src    = RES_NONE;
          state_next     = S_FIN;
        end else begin
          cmd.c_ld   = 1'b1;
          cmd.lra    = LRA_LDATA;
          state_next = S_FWALK;
        end
      end
      S_FWALK: begin
        if (stat.val_match) begin
          cmd.res_status = ST_OK;
          cmd.res_src    = RES_CUR;
          case (stat.op)
            OP_DELETE: begin
              // unlink node, then fetch free head
              cmd.lwe    = 1'b1;
              cmd.lwa    = LWA_PRED;
              cmd.lwd    = LWD_LDATA;
              cmd.lra    = LRA_FREE;
              state_next = S_D1;
            end
            OP_AMEND: begin
              cmd.vwe      = 1'b1;
              cmd.vw_amend = 1'b1;
              cmd.res_ld   = 1'b1;
              state_next   = S_FIN;
            end
            default: begin
              cmd.res_ld = 1'b1;
              state_next = S_FIN;
            end
          endcase
        end else if (stat.link_zero) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ST_NOTFND;
          cmd.res_src    = RES_NONE;
          state_next     = S_FIN;
        end else begin
          cmd.find_adv = 1'b1;
          cmd.lra      = LRA_LDATA;
        end
      end
      S_D1: begin
        cmd.lwe    = 1'b1;
        cmd.lwa    = LWA_CUR;
        cmd.lwd    = LWD_LDATA;
        state_next = S_D2;
      end
      S_D2: begin
        // push node on the free chain
        cmd.lwe        = 1'b1;
        cmd.lwa        = LWA_FREE;
        cmd.lwd        = LWD_CUR;
        cmd.res_ld     = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_src    = RES_CUR;
        state_next     = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    state != S_CLEAR |=> state != S_CLEAR)
    else $error("clearing pass reentered");

  a_fin_result: assert property (@(posedge clk) disable iff (rst)
    state_next == S_FIN && state != S_FIN && state != S_D1 |-> cmd.res_ld)
    else $error("finish without result");

endmodule

[design/cursor_linked_list_engine.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   operation, value, new_value, position
// out       output     out_valid/out_ready status, entry_index
//
// One request at a time. Insert walks position-1 list steps, clamped to the
// list length, and reports full when the free chain is empty; search, amend
// and delete walk the list node by node until the value is found or the list
// ends. The walk moves one node per cycle through the link memory read port.
// After reset a clearing pass builds the free chain; in_ready stays low during
// it. A stalled result holds the block before it returns idle.
module cursor_linked_list_engine import clle_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [31:0] value,
  input  logic signed [31:0] new_value,
  input  logic [15:0]        position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [5:0]         entry_index
);

  clle_cmd_t  cmd;
  clle_stat_t stat;

  clle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  clle_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .value       (value),
    .new_value   (new_value),
    .position    (position),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .entry_index (entry_index)
  );

endmodule
